FILE: rtl/mcc_pkg.sv
// Shared types, opcodes and constants of the microstepped 16-bit core.
package mcc_pkg;

  localparam int unsigned WordW = 16;

  // Register map of the configuration port
  localparam logic CFG_IDX_START = 1'b0;
  localparam logic [WordW-1:0] START_ADDR_RST = 16'hE000;

  // Micro-step numbers
  localparam logic [2:0] STEP_IDLE      = 3'd0;
  localparam logic [2:0] STEP_FETCH_OP  = 3'd1;
  localparam logic [2:0] STEP_FETCH_ARG = 3'd2;
  localparam logic [2:0] STEP_EXEC      = 3'd3;
  localparam logic [2:0] STEP_LAST      = 3'd5;

  // Flag bit positions
  localparam int unsigned FLAG_HALT   = 0;
  localparam int unsigned FLAG_CARRY  = 1;
  localparam int unsigned FLAG_EQUAL  = 2;
  localparam int unsigned FLAG_BORROW = 3;

  // Opcodes
  localparam logic [7:0] OP_HLT     = 8'h01;
  localparam logic [7:0] OP_ST      = 8'h10;
  localparam logic [7:0] OP_ST_IND  = 8'h11;
  localparam logic [7:0] OP_LD      = 8'h12;
  localparam logic [7:0] OP_LD_IND  = 8'h13;
  localparam logic [7:0] OP_LDI     = 8'h14;
  localparam logic [7:0] OP_MOV     = 8'h15;
  localparam logic [7:0] OP_GET_SP  = 8'h16;
  localparam logic [7:0] OP_SET_SP  = 8'h17;
  localparam logic [7:0] OP_CMPI    = 8'h20;
  localparam logic [7:0] OP_CMPM    = 8'h21;
  localparam logic [7:0] OP_CMPM_IND = 8'h22;
  localparam logic [7:0] OP_CMPR    = 8'h23;
  localparam logic [7:0] OP_JMP     = 8'h30;
  localparam logic [7:0] OP_BEQ     = 8'h31;
  localparam logic [7:0] OP_BLT     = 8'h32;
  localparam logic [7:0] OP_BNE     = 8'h33;
  localparam logic [7:0] OP_BCS     = 8'h34;
  localparam logic [7:0] OP_ADDR    = 8'h40;
  localparam logic [7:0] OP_ADDI    = 8'h41;
  localparam logic [7:0] OP_SUBR    = 8'h42;
  localparam logic [7:0] OP_SUBI    = 8'h43;
  localparam logic [7:0] OP_ANDR    = 8'h44;
  localparam logic [7:0] OP_ANDI    = 8'h45;
  localparam logic [7:0] OP_XORR    = 8'h46;
  localparam logic [7:0] OP_XORI    = 8'h47;
  localparam logic [7:0] OP_ORR     = 8'h48;
  localparam logic [7:0] OP_ORI     = 8'h49;
  localparam logic [7:0] OP_SHR     = 8'h4A;
  localparam logic [7:0] OP_PUSH    = 8'h50;
  localparam logic [7:0] OP_POP     = 8'h51;
  localparam logic [7:0] OP_CALL    = 8'h52;
  localparam logic [7:0] OP_RET     = 8'h53;
  localparam logic [7:0] OP_CLC     = 8'h60;
  localparam logic [7:0] OP_CLE     = 8'h61;
  localparam logic [7:0] OP_CLB     = 8'h62;

  typedef struct packed {
    logic [WordW-1:0] ip;
    logic [WordW-1:0] sp;
    logic [WordW-1:0] iw;
    logic [3:0]       flags;
    logic [2:0]       step;
    logic [WordW-1:0] addr;
    logic [WordW-1:0] dout;
    logic             wm;
  } core_state_t;

  typedef struct packed {
    logic             en;
    logic [WordW-1:0] data;
  } gp_wr_t;

  // Unsigned compare: keep halt and carry, recompute equal and borrow
  function automatic logic [3:0] cmp_flags(logic [3:0] flags, logic [WordW-1:0] a,
                                           logic [WordW-1:0] b);
    logic [3:0] f;
    f = flags & 4'b0011;
    f[FLAG_EQUAL]  = (a == b);
    f[FLAG_BORROW] = (a < b);
    return f;
  endfunction

endpackage

FILE: rtl/mcc_if.sv
// Valid/ready channel interfaces for read words in and bus results out.
interface mcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

interface mcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic [15:0] write_data;
  logic        write_strobe;
  logic [3:0]  status_flags;

  modport source (output valid, output bus_address, output write_data,
                  output write_strobe, output status_flags, input ready);
  modport sink (input valid, input bus_address, input write_data,
                input write_strobe, input status_flags, output ready);
endinterface

FILE: rtl/mcc_regfile.sv
// General register file: one write port, two registered read ports with bypass.
module mcc_regfile #(
  parameter int REG_COUNT = 16,
  localparam int IDX_W = $clog2(REG_COUNT)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] ra_addr_i,
  input  logic [IDX_W-1:0] rs_addr_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  output logic [15:0]      ra_data_o,
  output logic [15:0]      rs_data_o
);
  import mcc_pkg::*;

  logic [WordW-1:0] mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [WordW-1:0] ra_q;
  logic [WordW-1:0] rs_q;

  // An entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      if (we_i && (waddr_i == ra_addr_i)) begin
        ra_q <= wdata_i;
      end else if (vld_q[ra_addr_i]) begin
        ra_q <= mem_q[ra_addr_i];
      end else begin
        ra_q <= '0;
      end
      if (we_i && (waddr_i == rs_addr_i)) begin
        rs_q <= wdata_i;
      end else if (vld_q[rs_addr_i]) begin
        rs_q <= mem_q[rs_addr_i];
      end else begin
        rs_q <= '0;
      end
    end
  end

  assign ra_data_o = ra_q;
  assign rs_data_o = rs_q;

endmodule

FILE: rtl/mcc_exec.sv
// Next-state logic for one bus cycle: fetch steps and opcode execution.
module mcc_exec (
  input  mcc_pkg::core_state_t st_i,
  input  logic [15:0]          v_i,
  input  logic [15:0]          ra_i,
  input  logic [15:0]          rs_i,
  output mcc_pkg::core_state_t st_o,
  output mcc_pkg::gp_wr_t      wr_o
);
  import mcc_pkg::*;

  logic [2:0]       step_n;
  logic [7:0]       op;
  logic             done;
  logic [WordW-1:0] b;
  logic [WordW:0]   sum;
  logic [WordW-1:0] sp_inc;

  always_comb begin
    st_o      = st_i;
    wr_o.en   = 1'b0;
    wr_o.data = v_i;
    step_n    = st_i.step + 3'd1;
    op        = st_i.iw[15:8];
    done      = 1'b0;
    b         = v_i;
    sum       = '0;
    sp_inc    = st_i.sp + 16'd1;

    if (step_n == STEP_FETCH_OP) begin
      st_o.addr = st_i.ip;
      st_o.wm   = 1'b0;
      st_o.ip   = st_i.ip + 16'd1;
    end else if (step_n == STEP_FETCH_ARG) begin
      st_o.iw   = v_i;
      st_o.addr = st_i.ip;
      st_o.wm   = 1'b0;
      st_o.ip   = st_i.ip + 16'd1;
    end else begin
      done = 1'b1;
      case (op)
        OP_HLT: st_o.flags[FLAG_HALT] = 1'b1;
        OP_ST: begin
          st_o.addr = v_i;
          st_o.dout = ra_i;
          st_o.wm   = 1'b1;
        end
        OP_ST_IND: begin
          st_o.addr = v_i;
          if (step_n == STEP_EXEC) begin
            st_o.wm = 1'b0;
            done    = 1'b0;
          end else begin
            st_o.dout = ra_i;
            st_o.wm   = 1'b1;
          end
        end
        OP_LD: begin
          if (step_n == STEP_EXEC) begin
            st_o.addr = v_i;
            st_o.wm   = 1'b0;
            done      = 1'b0;
          end else begin
            wr_o.en = 1'b1;
          end
        end
        OP_LD_IND: begin
          if (step_n < STEP_LAST) begin
            st_o.addr = v_i;
            st_o.wm   = 1'b0;
            done      = 1'b0;
          end else begin
            wr_o.en = 1'b1;
          end
        end
        OP_LDI: wr_o.en = 1'b1;
        OP_MOV: begin
          wr_o.en   = 1'b1;
          wr_o.data = rs_i;
        end
        OP_GET_SP: begin
          wr_o.en   = 1'b1;
          wr_o.data = st_i.sp;
        end
        OP_SET_SP: st_o.sp = ra_i;
        OP_CMPI: st_o.flags = cmp_flags(st_i.flags, ra_i, v_i);
        OP_CMPM: begin
          if (step_n == STEP_EXEC) begin
            st_o.addr = v_i;
            st_o.wm   = 1'b0;
            done      = 1'b0;
          end else begin
            st_o.flags = cmp_flags(st_i.flags, ra_i, v_i);
          end
        end
        OP_CMPM_IND: begin
          if (step_n < STEP_LAST) begin
            st_o.addr = v_i;
            st_o.wm   = 1'b0;
            done      = 1'b0;
          end else begin
            st_o.flags = cmp_flags(st_i.flags, ra_i, v_i);
          end
        end
        OP_CMPR: st_o.flags = cmp_flags(st_i.flags, ra_i, rs_i);
        OP_JMP: st_o.ip = v_i;
        OP_BEQ: if (st_i.flags[FLAG_EQUAL]) st_o.ip = v_i;
        OP_BLT: if (st_i.flags[FLAG_BORROW]) st_o.ip = v_i;
        OP_BNE: if (!st_i.flags[FLAG_EQUAL]) st_o.ip = v_i;
        OP_BCS: if (st_i.flags[FLAG_CARRY]) st_o.ip = v_i;
        OP_ADDR, OP_ADDI: begin
          b         = (op == OP_ADDR) ? rs_i : v_i;
          sum       = {1'b0, ra_i} + {1'b0, b};
          wr_o.en   = 1'b1;
          wr_o.data = sum[WordW-1:0];
          if (sum[WordW]) st_o.flags[FLAG_CARRY] = 1'b1;
        end
        OP_SUBR, OP_SUBI: begin
          b         = (op == OP_SUBR) ? rs_i : v_i;
          wr_o.en   = 1'b1;
          wr_o.data = ra_i - b;
          if (ra_i < b) st_o.flags[FLAG_CARRY] = 1'b1;
        end
        OP_ANDR: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i & rs_i;
        end
        OP_ANDI: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i & v_i;
        end
        OP_XORR: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i ^ rs_i;
        end
        OP_XORI: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i ^ v_i;
        end
        OP_ORR: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i | rs_i;
        end
        OP_ORI: begin
          wr_o.en   = 1'b1;
          wr_o.data = ra_i | v_i;
        end
        OP_SHR: begin
          wr_o.en   = 1'b1;
          wr_o.data = {1'b0, ra_i[WordW-1:1]};
        end
        OP_PUSH: begin
          st_o.addr = st_i.sp;
          st_o.dout = ra_i;
          st_o.wm   = 1'b1;
          st_o.sp   = st_i.sp - 16'd1;
        end
        OP_POP, OP_RET: begin
          if (step_n == STEP_EXEC) begin
            // pre-increment, then read the top of stack
            st_o.sp   = sp_inc;
            st_o.addr = sp_inc;
            st_o.wm   = 1'b0;
            done      = 1'b0;
          end else if (op == OP_POP) begin
            wr_o.en = 1'b1;
          end else begin
            st_o.ip = v_i;
          end
        end
        OP_CALL: begin
          st_o.addr = st_i.sp;
          st_o.dout = st_i.ip;
          st_o.wm   = 1'b1;
          st_o.sp   = st_i.sp - 16'd1;
          st_o.ip   = v_i;
        end
        OP_CLC: st_o.flags[FLAG_CARRY] = 1'b0;
        OP_CLE: st_o.flags[FLAG_EQUAL] = 1'b0;
        OP_CLB: st_o.flags[FLAG_BORROW] = 1'b0;
        default: ;
      endcase
    end

    if (done || (step_n >= STEP_LAST)) begin
      st_o.step = STEP_IDLE;
    end else begin
      st_o.step = step_n;
    end
  end

endmodule

FILE: rtl/microstep_cpu_core_16bit.sv
// A read word waits in an input register; its bus result goes to a result register on out_o.
// Throughput: one word per cycle unless the output stalls; the two registers part the channels.
// The result register frees and refills in the same cycle, so a stalled output only holds input.
// Reset: flags, step counter, stack pointer and bus outputs clear; the instruction pointer
// loads 0xE000, as does the start register; the general registers read zero until written.
module microstep_cpu_core_16bit #(
  parameter int REG_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcc_in_if.sink      in_i,
  mcc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcc_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [WordW-1:0] start_q;
  core_state_t      st_q;
  core_state_t      st_d;
  core_state_t      exec_st;
  gp_wr_t           exec_wr;
  logic             in_vld_q;
  logic [WordW-1:0] v_q;
  logic             out_vld_q;
  logic             proc;
  logic             in_acc;
  logic             cfg_we;
  logic [WordW-1:0] ra_data;
  logic [WordW-1:0] rs_data;
  logic [IDX_W-1:0] idx_tab [256];

  // Register number modulo REG_COUNT, as a constant table
  for (genvar g = 0; g < 256; g++) begin : g_idx
    assign idx_tab[g] = IDX_W'(g % REG_COUNT);
  end

  assign proc   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = !in_vld_q || proc;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_IDX_START);
  assign prdata = (paddr[2] == CFG_IDX_START) ? {16'b0, start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_ADDR_RST;
    end else if (cfg_we) begin
      start_q <= pwdata[WordW-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= in_i.read_data;
    end
  end

  mcc_exec u_exec (
    .st_i (st_q),
    .v_i  (v_q),
    .ra_i (ra_data),
    .rs_i (rs_data),
    .st_o (exec_st),
    .wr_o (exec_wr)
  );

  assign st_d = proc ? exec_st : st_q;

  // Reads for the next word see the instruction word this cycle leaves behind
  mcc_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .ra_addr_i (idx_tab[st_d.iw[7:0]]),
    .rs_addr_i (idx_tab[in_i.read_data[7:0]]),
    .we_i      (proc && exec_wr.en),
    .waddr_i   (idx_tab[st_q.iw[7:0]]),
    .wdata_i   (exec_wr.data),
    .ra_data_o (ra_data),
    .rs_data_o (rs_data)
  );

  // Core state; the bus fields double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{ip: START_ADDR_RST, default: '0};
    end else if (proc) begin
      st_q <= st_d;
    end else if (cfg_we) begin
      st_q.ip <= pwdata[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.bus_address  = st_q.addr;
  assign out_o.write_data   = st_q.dout;
  assign out_o.write_strobe = st_q.wm;
  assign out_o.status_flags = st_q.flags;

endmodule

FILE: rtl/mcc_checker.sv
// Port-level checks for the core, bound to the top level.
module mcc_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] bus_address,
  input logic        write_strobe,
  input logic [3:0]  status_flags
);
  import mcc_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic       halt_seen_q;
  logic       last_wr_q;
  logic [1:0] pend_q;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
      last_wr_q   <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (out_acc) begin
        halt_seen_q <= halt_seen_q | status_flags[FLAG_HALT];
        last_wr_q   <= write_strobe;
      end
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(bus_address) && $stable(write_strobe))
    else $error("result changed while stalled");

  // Nothing clears halt
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && halt_seen_q |-> status_flags[FLAG_HALT])
    else $error("halt flag dropped");

  // Every write ends an instruction, so a fetch read follows
  a_no_wr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_wr_q |-> !write_strobe)
    else $error("two writes in a row");

  // At most two words in flight, and no result without a word behind it
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!out_valid || (pend_q != 2'd0)))
    else $error("result count does not match accepted words");

endmodule

bind microstep_cpu_core_16bit mcc_assert u_mcc_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .bus_address  (out_o.bus_address),
  .write_strobe (out_o.write_strobe),
  .status_flags (out_o.status_flags)
);
